### sv/osis_pkg.sv
// Shared types and constants for the ordered segment id set.
`timescale 1ns / 1ps

package osis_pkg;

    // Bitmap word geometry: one memory word holds this many membership bits.
    localparam int WORD_W  = 32;
    localparam int WORD_BW = 5;

    // Fixed field widths of the request and reply channels.
    localparam int ID_W    = 10;
    localparam int FUNC_W  = 3;
    localparam int COUNT_W = 11;

    // Operation codes carried in the func field of a request.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 3'd0,
        FUNC_REMOVE = 3'd1,
        FUNC_POP    = 3'd2,
        FUNC_QUERY  = 3'd3,
        FUNC_CLEAR  = 3'd4
    } t_func;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    // Everything the word unit derives from one bitmap word.
    typedef struct packed {
        logic               hit;
        logic               nonzero;
        logic [WORD_BW-1:0] low_idx;
        logic [WORD_W-1:0]  set_word;
        logic [WORD_W-1:0]  clr_word;
        logic [WORD_W-1:0]  pop_word;
    } t_word_res;

endpackage

### sv/ordered_segment_id_set.sv
// Top level of the ordered segment id set: sequencer, count and reply register.
`timescale 1ns / 1ps

// The set holds segment ids 0 to NUM_IDS-1 as a bitmap in a memory of
// 32-bit words (ceil(NUM_IDS/32) words) plus a member count. Requests
// are taken one at a time; o_ready is high only while the sequencer idles.
// Add, remove and query read the word and, for an add or remove that changes
// it, write it back modified, then load the reply register; an id at or
// above NUM_IDS and unused func codes go straight to the reply. Pop on an
// empty set also goes straight to the reply; otherwise it skips all-zero words
// while scanning upward from a low-water word index kept beside the count, so a
// pop usually finds its word at once. Clear sweeps zeros through every word,
// one per cycle, then loads the reply. After reset the same sweep runs
// before the first request is taken. A new request is accepted while an
// earlier reply still waits.
module ordered_segment_id_set #(
    parameter int NUM_IDS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [osis_pkg::FUNC_W-1:0]  i_func,
    input  logic [osis_pkg::ID_W-1:0]    i_segment_id,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [osis_pkg::ID_W-1:0]    o_result_id,
    output logic                         o_none_left,
    output logic                         o_was_present,
    output logic [osis_pkg::COUNT_W-1:0] o_member_count
);
    import osis_pkg::*;

    localparam int WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(NUM_IDS + 1);
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    // Sequencer and bookkeeping registers.
    t_state              r_state, n_state;
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [ID_W-1:0]     r_id, n_id;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_hint, n_hint;
    logic [AW-1:0]       r_scan, n_scan;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic                r_clr_reply, n_clr_reply;

    // Pending reply and the output register.
    logic [ID_W-1:0]     r_res_id, n_res_id;
    logic                r_res_none, n_res_none;
    logic                r_res_present, n_res_present;
    logic                r_out_valid, n_out_valid;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    logic                r_out_none, n_out_none;
    logic                r_out_present, n_out_present;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    // Memory and word unit connections.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;
    t_word_res           word_res;

    logic                in_range;
    logic [AW-1:0]       in_word;
    logic [AW-1:0]       scan_next;

    assign in_range  = 32'(i_segment_id) < 32'(NUM_IDS);
    assign in_word   = AW'(32'(i_segment_id) >> WORD_BW);
    assign scan_next = r_scan + AW'(1);

    osis_word_ram #(
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    osis_word_unit u_word (
        .i_word (ram_rdata),
        .i_bit  (r_id[WORD_BW-1:0]),
        .o_res  (word_res)
    );

    // State register and bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= '0;
            r_hint      <= LAST_WORD;
            r_scan      <= '0;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_hint      <= n_hint;
            r_scan      <= n_scan;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_id          <= n_id;
        r_res_id      <= n_res_id;
        r_res_none    <= n_res_none;
        r_res_present <= n_res_present;
        r_out_id      <= n_out_id;
        r_out_none    <= n_out_none;
        r_out_present <= n_out_present;
        r_out_count   <= n_out_count;
    end

    // Next state, memory control and reply formation.
    always_comb begin
        n_state       = r_state;
        n_func        = r_func;
        n_id          = r_id;
        n_count       = r_count;
        n_hint        = r_hint;
        n_scan        = r_scan;
        n_clr_addr    = r_clr_addr;
        n_clr_reply   = r_clr_reply;
        n_res_id      = r_res_id;
        n_res_none    = r_res_none;
        n_res_present = r_res_present;
        n_out_valid   = r_out_valid;
        n_out_id      = r_out_id;
        n_out_none    = r_out_none;
        n_out_present = r_out_present;
        n_out_count   = r_out_count;
        ram_we        = 1'b0;
        ram_waddr     = r_scan;
        ram_wdata     = '0;
        ram_raddr     = r_scan;
        o_ready       = 1'b0;

        // The reply leaves the output register when it is taken.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            // Sweep zeros through every word, after reset or for a clear.
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == LAST_WORD) begin
                    n_clr_addr = '0;
                    n_state    = r_clr_reply ? S_DONE : S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end

            // Take a request and start the word read it needs.
            S_IDLE: begin
                o_ready   = 1'b1;
                ram_raddr = (i_func == FUNC_POP) ? r_hint : in_word;
                if (i_valid) begin
                    n_func        = i_func;
                    n_id          = i_segment_id;
                    n_scan        = ram_raddr;
                    n_res_id      = '0;
                    n_res_none    = 1'b0;
                    n_res_present = 1'b0;
                    priority if (i_func == FUNC_ADD || i_func == FUNC_REMOVE ||
                                 i_func == FUNC_QUERY) begin
                        n_state = in_range ? S_EXEC : S_DONE;
                    end else if (i_func == FUNC_POP) begin
                        if (r_count == '0) begin
                            n_res_none = 1'b1;
                            n_state    = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (i_func == FUNC_CLEAR) begin
                        n_count     = '0;
                        n_hint      = LAST_WORD;
                        n_clr_reply = 1'b1;
                        n_clr_addr  = '0;
                        n_state     = S_CLEAR;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            // Test the addressed bit and, for an add or remove that changes it, write back the modified word.
            S_EXEC: begin
                n_res_present = word_res.hit;
                if (r_func == FUNC_ADD && !word_res.hit) begin
                    ram_we    = 1'b1;
                    ram_wdata = word_res.set_word;
                    n_count   = r_count + CW'(1);
                    if (r_scan < r_hint) begin
                        n_hint = r_scan;
                    end
                end else if (r_func == FUNC_REMOVE && word_res.hit) begin
                    ram_we    = 1'b1;
                    ram_wdata = word_res.clr_word;
                    n_count   = r_count - CW'(1);
                end
                n_state = S_DONE;
            end

            // Walk upward to the first nonzero word and take its lowest bit.
            S_SCAN: begin
                if (word_res.nonzero) begin
                    ram_we   = 1'b1;
                    ram_wdata = word_res.pop_word;
                    n_count  = r_count - CW'(1);
                    n_hint   = r_scan;
                    n_res_id = ID_W'((32'(r_scan) << WORD_BW) | 32'(word_res.low_idx));
                    n_state  = S_DONE;
                end else begin
                    ram_raddr = scan_next;
                    n_scan    = scan_next;
                end
            end

            // Move the reply into the output register once it is free.
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_id      = r_res_id;
                    n_out_none    = r_res_none;
                    n_out_present = r_res_present;
                    n_out_count   = COUNT_W'(32'(r_count));
                    n_clr_reply   = 1'b0;
                    n_state       = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_result_id    = r_out_id;
    assign o_none_left    = r_out_none;
    assign o_was_present  = r_out_present;
    assign o_member_count = r_out_count;

endmodule

### sv/osis_word_ram.sv
// Bitmap word memory with one write port and one registered read port.
`timescale 1ns / 1ps

module osis_word_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [osis_pkg::WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [osis_pkg::WORD_W-1:0] o_rdata
);
    import osis_pkg::*;

    logic [WORD_W-1:0] r_mem [0:DEPTH-1];
    logic [WORD_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/osis_word_unit.sv
// Shared word unit: bit test, set, clear and lowest-set-bit search on one word.
`timescale 1ns / 1ps

module osis_word_unit (
    input  logic [osis_pkg::WORD_W-1:0]  i_word,
    input  logic [osis_pkg::WORD_BW-1:0] i_bit,
    output osis_pkg::t_word_res          o_res
);
    import osis_pkg::*;

    logic [WORD_W-1:0]  mask;
    logic [WORD_W-1:0]  low_onehot;
    logic [WORD_BW-1:0] low_idx;

    assign mask = {{(WORD_W-1){1'b0}}, 1'b1} << i_bit;

    // Isolate the lowest set bit, then encode its position with an OR per bit.
    assign low_onehot = i_word & (~i_word + {{(WORD_W-1){1'b0}}, 1'b1});

    always_comb begin
        low_idx = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (low_onehot[b]) begin
                low_idx = low_idx | WORD_BW'(b);
            end
        end
    end

    assign o_res.hit      = |(i_word & mask);
    assign o_res.nonzero  = |i_word;
    assign o_res.low_idx  = low_idx;
    assign o_res.set_word = i_word | mask;
    assign o_res.clr_word = i_word & ~mask;
    assign o_res.pop_word = i_word & ~low_onehot;

endmodule

### dv/segment_set_monitor.sv
// Reply checker for the ordered segment id set: tracks the set and compares every reply.
`timescale 1ns / 1ps

module segment_set_monitor #(
    parameter int NUM_IDS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_ready_req,
    input  logic [osis_pkg::FUNC_W-1:0]  i_func,
    input  logic [osis_pkg::ID_W-1:0]    i_segment_id,
    input  logic                         i_valid_rep,
    input  logic                         i_ready,
    input  logic [osis_pkg::ID_W-1:0]    i_result_id,
    input  logic                         i_none_left,
    input  logic                         i_was_present,
    input  logic [osis_pkg::COUNT_W-1:0] i_member_count,
    output int                           o_fail_count,
    output int                           o_pending
);
    import osis_pkg::*;

    // One expected reply.
    typedef struct packed {
        logic [ID_W-1:0]    result_id;
        logic               none_left;
        logic               was_present;
        logic [COUNT_W-1:0] member_count;
    } t_set_reply;

    logic [NUM_IDS-1:0]      member_map;
    logic [COUNT_W-1:0]      member_tally;
    t_set_reply              expected_replies[$];
    int                      fail_count;

    assign o_fail_count = fail_count;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // Applies one request to the tracked set and returns the reply it must produce.
    function automatic t_set_reply apply_set_op(input logic [FUNC_W-1:0] func,
                                                input logic [ID_W-1:0]   seg_id);
        t_set_reply rep;
        logic       in_range;
        logic       present;
        int         lowest;
        rep      = '0;
        in_range = (int'(seg_id) < NUM_IDS);
        present  = in_range && member_map[seg_id];
        lowest   = -1;
        case (func)
            FUNC_ADD: begin
                if (present) begin
                    rep.was_present = 1'b1;
                end else if (in_range) begin
                    member_map[seg_id] = 1'b1;
                    member_tally++;
                end
            end
            FUNC_REMOVE: begin
                if (present) begin
                    rep.was_present    = 1'b1;
                    member_map[seg_id] = 1'b0;
                    member_tally--;
                end
            end
            FUNC_POP: begin
                for (int k = 0; k < NUM_IDS && lowest < 0; k++) begin
                    if (member_map[k]) lowest = k;
                end
                if (lowest >= 0) begin
                    member_map[lowest] = 1'b0;
                    member_tally--;
                    rep.result_id = ID_W'(lowest);
                end else begin
                    rep.none_left = 1'b1;
                end
            end
            FUNC_QUERY: begin
                rep.was_present = present;
            end
            FUNC_CLEAR: begin
                member_map   = '0;
                member_tally = '0;
            end
            default: begin
                // Spare codes leave the set alone.
            end
        endcase
        rep.member_count = member_tally;
        return rep;
    endfunction

    // Check the reply first, then predict the request taken at the same edge.
    always @(posedge i_clk) begin
        t_set_reply want;
        if (!i_rst_n) begin
            member_map   = '0;
            member_tally = '0;
            expected_replies.delete();
        end else begin
            if (i_valid_rep && i_ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf("reply with none expected (id %0d, count %0d)",
                                              i_result_id, i_member_count));
                end else begin
                    want = expected_replies.pop_front();
                    if (i_result_id !== want.result_id)
                        report_mismatch($sformatf("result_id: got %0d, expected %0d",
                                                  i_result_id, want.result_id));
                    if (i_none_left !== want.none_left)
                        report_mismatch($sformatf("none_left: got %0b, expected %0b",
                                                  i_none_left, want.none_left));
                    if (i_was_present !== want.was_present)
                        report_mismatch($sformatf("was_present: got %0b, expected %0b",
                                                  i_was_present, want.was_present));
                    if (i_member_count !== want.member_count)
                        report_mismatch($sformatf("member_count: got %0d, expected %0d",
                                                  i_member_count, want.member_count));
                end
            end
            if (i_valid && i_ready_req) begin
                expected_replies.push_back(apply_set_op(i_func, i_segment_id));
            end
        end
        o_pending = expected_replies.size();
    end

    initial begin
        fail_count   = 0;
        o_pending    = 0;
        member_map   = '0;
        member_tally = '0;
    end

endmodule

### dv/tb_ordered_segment_id_set.sv
// Testbench top for the ordered segment id set: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_ordered_segment_id_set;
    import osis_pkg::*;

    localparam int NUM_IDS         = 1024;
    localparam int MAX_ID          = (1 << ID_W) - 1;
    localparam int FILL_COUNT      = 192;
    localparam int RANDOM_REQUESTS = 300;
    localparam int SETTLE_CYCLES   = 64;
    localparam int CYCLE_LIMIT     = 1000000;

    // Func codes the block does not define.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_MID   = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

    typedef enum int {
        MODE_GROW,
        MODE_DRAIN,
        MODE_MIXED,
        MODE_NOISE
    } t_burst_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [FUNC_W-1:0]  i_func;
    logic [ID_W-1:0]    i_segment_id;
    logic               o_valid;
    logic               i_ready;
    logic [ID_W-1:0]    o_result_id;
    logic               o_none_left;
    logic               o_was_present;
    logic [COUNT_W-1:0] o_member_count;

    int fail_count;
    int pending;
    int cycle_count;
    bit calm;

    ordered_segment_id_set #(
        .NUM_IDS(NUM_IDS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_segment_id   (i_segment_id),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_id    (o_result_id),
        .o_none_left    (o_none_left),
        .o_was_present  (o_was_present),
        .o_member_count (o_member_count)
    );

    segment_set_monitor #(
        .NUM_IDS(NUM_IDS)
    ) u_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_ready_req    (o_ready),
        .i_func         (i_func),
        .i_segment_id   (i_segment_id),
        .i_valid_rep    (o_valid),
        .i_ready        (i_ready),
        .i_result_id    (o_result_id),
        .i_none_left    (o_none_left),
        .i_was_present  (o_was_present),
        .i_member_count (o_member_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Clock with a 20 ns period.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Hard stop if the run hangs.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Presents one request at a falling edge and holds it until it is taken.
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] seg_id);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= func;
        i_segment_id <= seg_id;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Reply side: ready runs of random length, broken by stalls.
    initial begin
        int run;
        int stall;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 9) == 0) run = $urandom_range(100, 300);
            else run = $urandom_range(1, 12);
            stall = pick_gap();
            @(negedge i_clk);
            i_ready <= 1'b1;
            repeat (run - 1) @(negedge i_clk);
            if (stall > 0) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    // Request stimulus and verdict.
    initial begin
        int          order [NUM_IDS];
        int          pick;
        int          tmp;
        int          issued;
        int          burst_len;
        int          win;
        int          base;
        int          r;
        t_burst_mode mode;
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   seg_id;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_func       = FUNC_ADD;
        i_segment_id = '0;
        calm         = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pop, id extremes, duplicates, word edges, spare codes, clear.
        send_request(FUNC_POP, ID_W'(MAX_ID));
        send_request(FUNC_QUERY, '0);
        send_request(FUNC_ADD, '0);
        send_request(FUNC_ADD, ID_W'(MAX_ID));
        send_request(FUNC_ADD, '0);
        send_request(FUNC_QUERY, ID_W'(MAX_ID));
        send_request(FUNC_QUERY, ID_W'(512));
        send_request(FUNC_REMOVE, ID_W'(512));
        send_request(FUNC_POP, '0);
        send_request(FUNC_POP, '0);
        send_request(FUNC_POP, ID_W'(MAX_ID));
        send_request(FUNC_ADD, ID_W'(5));
        send_request(FUNC_SPARE_FIRST, ID_W'(MAX_ID));
        send_request(FUNC_SPARE_MID, ID_W'(5));
        send_request(FUNC_SPARE_LAST, '0);
        send_request(FUNC_CLEAR, ID_W'(MAX_ID));
        send_request(FUNC_POP, '0);
        send_request(FUNC_QUERY, ID_W'(5));
        send_request(FUNC_REMOVE, ID_W'(5));
        send_request(FUNC_ADD, ID_W'(32));
        send_request(FUNC_ADD, ID_W'(31));
        send_request(FUNC_POP, '0);
        send_request(FUNC_POP, '0);
        send_request(FUNC_ADD, ID_W'(MAX_ID));
        send_request(FUNC_REMOVE, ID_W'(MAX_ID));

        // Scatter a shuffled batch of ids over the whole range so pops cross many words.
        for (int k = 0; k < NUM_IDS; k++) order[k] = k;
        for (int k = NUM_IDS - 1; k > 0; k--) begin
            pick        = $urandom_range(0, k);
            tmp         = order[k];
            order[k]    = order[pick];
            order[pick] = tmp;
        end
        for (int k = 0; k < FILL_COUNT; k++) begin
            calm = (k % 256) < 64;
            send_request(FUNC_ADD, ID_W'(order[k]));
            if ($urandom_range(0, 15) == 0) begin
                send_request(FUNC_QUERY, ID_W'($urandom_range(0, MAX_ID)));
            end
        end
        calm = 1'b0;
        send_request(FUNC_ADD, ID_W'($urandom_range(0, MAX_ID)));
        repeat (3) send_request(FUNC_POP, '0);
        send_request(FUNC_CLEAR, '0);

        // Random bursts: each works a window of ids so adds, removes and pops meet members.
        issued = 0;
        while (issued < RANDOM_REQUESTS) begin
            mode      = t_burst_mode'($urandom_range(0, 3));
            burst_len = $urandom_range(10, 40);
            calm      = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 2))
                0:       win = 31;
                1:       win = 63;
                default: win = 255;
            endcase
            r = $urandom_range(0, 99);
            if (r < 20) base = 0;
            else if (r < 35) base = MAX_ID - win;
            else base = $urandom_range(0, MAX_ID - win);
            repeat (burst_len) begin
                r      = $urandom_range(0, 99);
                seg_id = ID_W'(base + $urandom_range(0, win));
                case (mode)
                    MODE_GROW: begin
                        func = (r < 60) ? FUNC_ADD : (r < 75) ? FUNC_QUERY :
                               (r < 85) ? FUNC_REMOVE : FUNC_POP;
                    end
                    MODE_DRAIN: begin
                        func = (r < 45) ? FUNC_POP : (r < 75) ? FUNC_REMOVE :
                               (r < 85) ? FUNC_ADD : FUNC_QUERY;
                    end
                    MODE_MIXED: begin
                        func = (r < 30) ? FUNC_ADD : (r < 50) ? FUNC_REMOVE :
                               (r < 70) ? FUNC_POP : (r < 97) ? FUNC_QUERY : FUNC_CLEAR;
                    end
                    default: begin
                        if (r < 75) func = FUNC_W'($urandom_range(FUNC_ADD, FUNC_CLEAR));
                        else func = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
                        seg_id = ID_W'($urandom_range(0, MAX_ID));
                    end
                endcase
                send_request(func, seg_id);
                issued++;
            end
        end

        // Drain the outstanding replies, then give late replies a chance to show up.
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/osis_pkg.sv
sv/osis_word_ram.sv
sv/osis_word_unit.sv
sv/ordered_segment_id_set.sv
dv/segment_set_monitor.sv
dv/tb_ordered_segment_id_set.sv
